// File: rtl/core/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg
// Shared types, widths and constants of the audio rate estimator.
// ----------------------------------------------------------------------------
package ard_pkg;

    localparam int FRACTION_BITS = 5;
    localparam int QUEUE_DEPTH   = 64;
    localparam int QADDR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SAMPLE_W   = 20;
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 24;
    localparam int RATE_W     = 20;
    localparam int OUT_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WSUM_W     = 32;
    localparam int LSS_W      = 40;
    localparam int LTS_W      = 32;
    localparam int SUM_SHIFT  = 5;
    localparam int ENTRY_W    = SAMPLE_W + GAP_W;

    // scaled reference rate and smoothed state widths
    localparam int RW    = RATE_W + FRACTION_BITS;
    localparam int SR_W  = RW + 1;
    localparam int QUO_W = 41;
    localparam int EST_W = QUO_W + 1;

    localparam longint unsigned RATE_SCALE_VAL = 64'd1000000 << FRACTION_BITS;
    localparam int SCALE_W = $clog2(RATE_SCALE_VAL + 1);
    localparam int DVD_W   = LSS_W + SCALE_W + 1;
    localparam int CNT_W   = $clog2(DVD_W);

    localparam logic [SCALE_W-1:0] RATE_SCALE   = SCALE_W'(RATE_SCALE_VAL);
    localparam logic [WSUM_W-1:0]  WINDOW_US    = WSUM_W'(100000);
    localparam logic [LTS_W-1:0]   LTS_INIT     = LTS_W'(64'd12000000 << 5);
    localparam logic [LTS_W-1:0]   SHRINK_LIMIT = LTS_W'(64'd16000000 << 5);
    localparam logic [QUO_W-1:0]   ESAT         = QUO_W'(64'd1 << (QUO_W - 1));

    localparam logic [RATE_W-1:0] REF_DEFAULT     = RATE_W'(48000);
    localparam logic [RATE_W-1:0] INIT_DEFAULT    = RATE_W'(48000);
    localparam logic [GAP_W-1:0]  MAX_GAP_DEFAULT = GAP_W'(100000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFERENCE_RATE = 2'd0,
        CFG_INITIAL_RATE   = 2'd1,
        CFG_MAX_GAP_US     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic [LSS_W-1:0] mcand;
        logic [LTS_W-1:0] bias;
        logic [LTS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_resp_t;

    function automatic logic [SR_W-1:0] clamp_band(input logic [EST_W-1:0] e,
                                                   input logic [RW-1:0] r);
        logic [SR_W-1:0] band;
        logic [SR_W-1:0] hi;
        logic [SR_W-1:0] lo;
        band = SR_W'(r >> 6);
        hi   = SR_W'(r) + band;
        lo   = SR_W'(r) - band;
        if (e > EST_W'(hi))
            return hi;
        else if (e < EST_W'(lo))
            return lo;
        else
            return SR_W'(e);
    endfunction

endpackage

// File: rtl/core/ard_report_if.sv
// ----------------------------------------------------------------------------
// ard_report_if
// Report channel: sample count and microsecond timestamp.
// ----------------------------------------------------------------------------
interface ard_report_if;
    logic                         valid;
    logic                         ready;
    logic [ard_pkg::SAMPLE_W-1:0] sample_count;
    logic [ard_pkg::TIME_W-1:0]   now_us;

    modport source (output valid, sample_count, now_us, input ready);
    modport sink (input valid, sample_count, now_us, output ready);
endinterface

// File: rtl/core/ard_result_if.sv
// ----------------------------------------------------------------------------
// ard_result_if
// Result channel: smoothed rate estimate and its variation.
// ----------------------------------------------------------------------------
interface ard_result_if;
    logic                      valid;
    logic                      ready;
    logic [ard_pkg::OUT_W-1:0] rate_estimate;
    logic [ard_pkg::OUT_W-1:0] rate_variation;

    modport source (output valid, rate_estimate, rate_variation, input ready);
    modport sink (input valid, rate_estimate, rate_variation, output ready);
endinterface

// File: rtl/core/ard_cfg_if.sv
// ----------------------------------------------------------------------------
// ard_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ard_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ard_pkg::CFG_IDX_W-1:0]  index;
    logic [ard_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/audio_rate_estimator.sv
// ----------------------------------------------------------------------------
// audio_rate_estimator
// Sample rate estimator fed by sample count / timestamp reports.
// ----------------------------------------------------------------------------
// One report yields one result. The time between requests is set by the
// window pops that a report triggers. A rejected report goes straight to
// the finish state. An accepted report is pushed into the 100 ms window and
// checked; when the queue is full its oldest pair is dropped first. Every
// pair popped from the window costs one pass of the shared multiply/divide
// unit (shift-add multiply by the scale constant, the quotient bits and the
// done flag) plus a window check. A popped pair whose window rate is in
// band costs a second pass, when the time sum is nonzero, plus the sums,
// start, smoothing and shrinking steps. The block is not ready while a
// report is in progress; a finished result waits in an output register,
// and a stalled result side holds the block until that register is free.
// After reset and after every register write the block reloads its state
// in an init state before it takes the next request.
module audio_rate_estimator (
    input  logic                clk,
    input  logic                rst_n,
    ard_report_if.sink          report,
    ard_result_if.source        result,
    ard_cfg_if.sink             cfg
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FULL_RD,
        S_FULL_POP,
        S_PUSH,
        S_CHECK,
        S_WDIV,
        S_SUMS,
        S_ESTART,
        S_EDIV,
        S_SMOOTH,
        S_SHRINK,
        S_FINISH
    } state_t;

    state_t                             state_reg, state_next;
    logic [ard_pkg::RATE_W-1:0]         ref_reg, ref_next;
    logic [ard_pkg::RATE_W-1:0]         init_reg, init_next;
    logic [ard_pkg::GAP_W-1:0]          gap_max_reg, gap_max_next;
    logic [ard_pkg::TIME_W-1:0]         last_reg, last_next;
    logic [ard_pkg::QADDR_W-1:0]        head_reg, head_next;
    logic [ard_pkg::QCOUNT_W-1:0]       count_reg, count_next;
    logic [ard_pkg::WSUM_W-1:0]         ws_reg, ws_next;
    logic [ard_pkg::WSUM_W-1:0]         wt_reg, wt_next;
    logic                               out_valid_reg, out_valid_next;
    logic [ard_pkg::OUT_W-1:0]          est_out_reg, est_out_next;
    logic [ard_pkg::OUT_W-1:0]          var_out_reg, var_out_next;

    logic [ard_pkg::SAMPLE_W-1:0]       samples_reg, samples_next;
    logic [ard_pkg::GAP_W-1:0]          gap_reg, gap_next;
    logic [ard_pkg::SR_W-1:0]           sr_reg, sr_next;
    logic [ard_pkg::SR_W-1:0]           sv_reg, sv_next;
    logic [ard_pkg::SR_W-1:0]           ec_reg, ec_next;
    logic [ard_pkg::LSS_W-1:0]          lss_reg, lss_next;
    logic [ard_pkg::LTS_W-1:0]          lts_reg, lts_next;

    ard_pkg::div_req_t                  div_req;
    ard_pkg::div_resp_t                 div_resp;

    logic                               ram_wr_en;
    logic [ard_pkg::QADDR_W-1:0]        ram_wr_addr;
    logic                               ram_rd_en;
    logic [ard_pkg::ENTRY_W-1:0]        ram_rd_data;

    logic [ard_pkg::RW-1:0]             r_val;
    logic [ard_pkg::RW-1:0]             r_half;
    logic [ard_pkg::SAMPLE_W-1:0]       rd_samples;
    logic [ard_pkg::GAP_W-1:0]          rd_gap;
    logic [ard_pkg::TIME_W-1:0]         gap_now;
    logic                               report_ok;
    logic                               queue_full;
    logic                               win_over;
    logic [ard_pkg::QADDR_W:0]          slot_sum;
    logic [ard_pkg::QADDR_W-1:0]        head_inc;
    logic [ard_pkg::QUO_W-1:0]          dev;
    logic                               in_band;
    logic [ard_pkg::EST_W-1:0]          e_sum;
    logic [ard_pkg::SR_W-1:0]           e_clamped;
    logic [ard_pkg::SR_W-1:0]           d_abs;
    logic [ard_pkg::SR_W+4:0]           v_sum;
    logic [ard_pkg::LSS_W:0]            lss_add;
    logic [ard_pkg::LTS_W:0]            lts_add;
    logic [ard_pkg::LSS_W+1:0]          lss_shr;
    logic [ard_pkg::LTS_W+1:0]          lts_shr;
    logic [ard_pkg::RW-1:0]             s_init;
    logic [ard_pkg::SR_W-1:0]           sr_init;
    logic [ard_pkg::SR_W-1:0]           sr_whole;
    logic [ard_pkg::SR_W-1:0]           band_lo;
    logic [ard_pkg::SR_W-1:0]           band_hi;

    ard_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    ard_ram #(
        .WIDTH (ard_pkg::ENTRY_W),
        .DEPTH (ard_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({samples_reg, gap_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign r_val      = ard_pkg::RW'(ref_reg) << ard_pkg::FRACTION_BITS;
    assign r_half     = r_val >> 1;
    assign band_lo    = ard_pkg::SR_W'(r_val) - ard_pkg::SR_W'(r_val >> 6);
    assign band_hi    = ard_pkg::SR_W'(r_val) + ard_pkg::SR_W'(r_val >> 6);
    assign rd_samples = ram_rd_data[ard_pkg::ENTRY_W-1 -: ard_pkg::SAMPLE_W];
    assign rd_gap     = ram_rd_data[ard_pkg::GAP_W-1:0];
    assign gap_now    = report.now_us - last_reg;
    assign report_ok  = (last_reg != '0)
                        && (gap_now < ard_pkg::TIME_W'(gap_max_reg));
    assign queue_full = count_reg == ard_pkg::QCOUNT_W'(ard_pkg::QUEUE_DEPTH);
    assign win_over   = (wt_reg > ard_pkg::WINDOW_US) && (count_reg != '0);

    // write slot is head + count, wrapped at the queue depth
    always_comb
    begin
        slot_sum = (ard_pkg::QADDR_W+1)'(head_reg) + (ard_pkg::QADDR_W+1)'(count_reg);
        if (slot_sum >= (ard_pkg::QADDR_W+1)'(ard_pkg::QUEUE_DEPTH))
            slot_sum = slot_sum - (ard_pkg::QADDR_W+1)'(ard_pkg::QUEUE_DEPTH);
    end

    assign ram_wr_addr = slot_sum[ard_pkg::QADDR_W-1:0];
    assign head_inc    = (head_reg == ard_pkg::QADDR_W'(ard_pkg::QUEUE_DEPTH - 1))
                         ? '0 : head_reg + 1'b1;
    assign ram_wr_en   = state_reg == S_PUSH;
    assign ram_rd_en   = (state_reg == S_FULL_RD) || (state_reg == S_CHECK && win_over);

    // window rate check against half of nominal
    assign dev = (div_resp.quotient > ard_pkg::QUO_W'(r_val))
                 ? div_resp.quotient - ard_pkg::QUO_W'(r_val)
                 : ard_pkg::QUO_W'(r_val) - div_resp.quotient;
    assign in_band = dev < ard_pkg::QUO_W'(r_half);

    // 31/32 smoothing of the new estimate
    assign e_sum = (ard_pkg::EST_W'(sr_reg) << 5) - ard_pkg::EST_W'(sr_reg)
                   + ard_pkg::EST_W'(div_resp.quotient) + ard_pkg::EST_W'(16);
    assign e_clamped = ard_pkg::clamp_band(e_sum >> 5, r_val);

    assign d_abs = (ec_reg > sr_reg) ? ec_reg - sr_reg : sr_reg - ec_reg;
    assign v_sum = ((ard_pkg::SR_W+5)'(sv_reg) << 4)
                   - (ard_pkg::SR_W+5)'(sv_reg) + (ard_pkg::SR_W+5)'(d_abs)
                   + (ard_pkg::SR_W+5)'(8);

    assign lss_add = (ard_pkg::LSS_W+1)'(lss_reg)
                     + ((ard_pkg::LSS_W+1)'(rd_samples) << ard_pkg::SUM_SHIFT);
    assign lts_add = (ard_pkg::LTS_W+1)'(lts_reg)
                     + ((ard_pkg::LTS_W+1)'(rd_gap) << ard_pkg::SUM_SHIFT);
    assign lss_shr = (((ard_pkg::LSS_W+2)'(lss_reg) << 1) + (ard_pkg::LSS_W+2)'(lss_reg)
                     + (ard_pkg::LSS_W+2)'(2)) >> 2;
    assign lts_shr = (((ard_pkg::LTS_W+2)'(lts_reg) << 1) + (ard_pkg::LTS_W+2)'(lts_reg)
                     + (ard_pkg::LTS_W+2)'(2)) >> 2;

    assign s_init   = ard_pkg::RW'(init_reg) << ard_pkg::FRACTION_BITS;
    assign sr_init  = ard_pkg::clamp_band(ard_pkg::EST_W'(s_init), r_val);
    assign sr_whole = sr_init >> ard_pkg::FRACTION_BITS;

    always_comb
    begin
        div_req.start   = (state_reg == S_CHECK && win_over)
                          || (state_reg == S_ESTART && lts_reg != '0);
        div_req.mcand   = (state_reg == S_CHECK) ? ard_pkg::LSS_W'(ws_reg) : lss_reg;
        div_req.bias    = (state_reg == S_CHECK) ? '0 : lts_reg >> 1;
        div_req.divisor = (state_reg == S_CHECK) ? wt_reg : lts_reg;
    end

    assign cfg.ready    = state_reg == S_IDLE;
    assign report.ready = (state_reg == S_IDLE) && !cfg.valid;

    always_comb
    begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        init_next      = init_reg;
        gap_max_next   = gap_max_reg;
        last_next      = last_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ws_next        = ws_reg;
        wt_next        = wt_reg;
        out_valid_next = out_valid_reg;
        est_out_next   = est_out_reg;
        var_out_next   = var_out_reg;
        samples_next   = samples_reg;
        gap_next       = gap_reg;
        sr_next        = sr_reg;
        sv_next        = sv_reg;
        ec_next        = ec_reg;
        lss_next       = lss_reg;
        lts_next       = lts_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                sr_next    = sr_init;
                sv_next    = ard_pkg::SR_W'(s_init >> 12);
                lss_next   = ((ard_pkg::LSS_W'(sr_whole) << 3)
                              + (ard_pkg::LSS_W'(sr_whole) << 2)) << 5;
                lts_next   = ard_pkg::LTS_INIT;
                last_next  = '0;
                head_next  = '0;
                count_next = '0;
                ws_next    = '0;
                wt_next    = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg.valid)
                begin
                    unique case (cfg.index)
                        ard_pkg::CFG_REFERENCE_RATE:
                        begin
                            ref_next   = cfg.data[ard_pkg::RATE_W-1:0];
                            state_next = S_INIT;
                        end
                        ard_pkg::CFG_INITIAL_RATE:
                        begin
                            init_next  = cfg.data[ard_pkg::RATE_W-1:0];
                            state_next = S_INIT;
                        end
                        ard_pkg::CFG_MAX_GAP_US:
                        begin
                            gap_max_next = cfg.data;
                            state_next   = S_INIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else if (report.valid)
                begin
                    samples_next = report.sample_count;
                    gap_next     = gap_now[ard_pkg::GAP_W-1:0];
                    last_next    = report.now_us;
                    if (!report_ok)
                        state_next = S_FINISH;
                    else if (queue_full)
                        state_next = S_FULL_RD;
                    else
                        state_next = S_PUSH;
                end
            end
            S_FULL_RD:
            begin
                state_next = S_FULL_POP;
            end
            S_FULL_POP:
            begin
                ws_next    = ws_reg - ard_pkg::WSUM_W'(rd_samples);
                wt_next    = wt_reg - ard_pkg::WSUM_W'(rd_gap);
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                count_next = count_reg + 1'b1;
                ws_next    = ws_reg + ard_pkg::WSUM_W'(samples_reg);
                wt_next    = wt_reg + ard_pkg::WSUM_W'(gap_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (win_over)
                    state_next = S_WDIV;
                else
                    state_next = S_FINISH;
            end
            S_WDIV:
            begin
                if (div_resp.done)
                begin
                    ws_next    = ws_reg - ard_pkg::WSUM_W'(rd_samples);
                    wt_next    = wt_reg - ard_pkg::WSUM_W'(rd_gap);
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    if (in_band)
                        state_next = S_SUMS;
                    else
                        state_next = S_CHECK;
                end
            end
            S_SUMS:
            begin
                lss_next   = lss_add[ard_pkg::LSS_W] ? '1 : lss_add[ard_pkg::LSS_W-1:0];
                lts_next   = lts_add[ard_pkg::LTS_W] ? '1 : lts_add[ard_pkg::LTS_W-1:0];
                state_next = S_ESTART;
            end
            S_ESTART:
            begin
                // zero time sum leaves the estimate alone
                if (lts_reg == '0)
                    state_next = S_CHECK;
                else
                    state_next = S_EDIV;
            end
            S_EDIV:
            begin
                if (div_resp.done)
                begin
                    ec_next    = e_clamped;
                    state_next = S_SMOOTH;
                end
            end
            S_SMOOTH:
            begin
                sv_next    = ard_pkg::SR_W'(v_sum >> 4);
                sr_next    = ec_reg;
                state_next = S_SHRINK;
            end
            S_SHRINK:
            begin
                if (lts_reg > ard_pkg::SHRINK_LIMIT)
                begin
                    lss_next = lss_shr[ard_pkg::LSS_W-1:0];
                    lts_next = lts_shr[ard_pkg::LTS_W-1:0];
                end
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    est_out_next   = ard_pkg::OUT_W'(sr_reg);
                    var_out_next   = ard_pkg::OUT_W'(sv_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ref_reg       <= ard_pkg::REF_DEFAULT;
            init_reg      <= ard_pkg::INIT_DEFAULT;
            gap_max_reg   <= ard_pkg::MAX_GAP_DEFAULT;
            last_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            ws_reg        <= '0;
            wt_reg        <= '0;
            out_valid_reg <= 1'b0;
            est_out_reg   <= '0;
            var_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            init_reg      <= init_next;
            gap_max_reg   <= gap_max_next;
            last_reg      <= last_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ws_reg        <= ws_next;
            wt_reg        <= wt_next;
            out_valid_reg <= out_valid_next;
            est_out_reg   <= est_out_next;
            var_out_reg   <= var_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samples_reg <= samples_next;
        gap_reg     <= gap_next;
        sr_reg      <= sr_next;
        sv_reg      <= sv_next;
        ec_reg      <= ec_next;
        lss_reg     <= lss_next;
        lts_reg     <= lts_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.rate_estimate  = est_out_reg;
    assign result.rate_variation = var_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ard_pkg::QCOUNT_W'(ard_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> ws_reg == '0 && wt_reg == '0)
        else $error("window sums nonzero with empty queue");

    a_rate_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> sr_reg >= band_lo && sr_reg <= band_hi)
        else $error("smoothed rate outside nominal band");

endmodule

// File: rtl/core/ard_ram.sv
// ----------------------------------------------------------------------------
// ard_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/ard_divider.sv
// ----------------------------------------------------------------------------
// ard_divider
// Iterative unit: (mcand * RATE_SCALE + bias) / divisor, saturated at 2^40.
// Shift-add multiply by the scale constant, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ard_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  ard_pkg::div_req_t  req,
    output ard_pkg::div_resp_t resp
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } dstate_t;

    dstate_t                          state_reg, state_next;
    logic [ard_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ard_pkg::SCALE_W-1:0]      kbits_reg, kbits_next;
    logic [ard_pkg::DVD_W-1:0]        acc_reg, acc_next;
    logic [ard_pkg::DVD_W-1:0]        mcand_reg, mcand_next;
    logic [ard_pkg::DVD_W-1:0]        quo_reg, quo_next;
    logic [ard_pkg::LTS_W-1:0]        divisor_reg, divisor_next;
    logic [ard_pkg::LTS_W-1:0]        rem_reg, rem_next;
    logic                             done_reg, done_next;
    logic [ard_pkg::QUO_W-1:0]        result_reg, result_next;

    logic [ard_pkg::LTS_W:0]          partial;
    logic [ard_pkg::LTS_W+1:0]        diff;
    logic                             ge;

    assign partial = {rem_reg, acc_reg[ard_pkg::DVD_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, divisor_reg};
    assign ge      = ~diff[ard_pkg::LTS_W+1];

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        kbits_next   = kbits_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    acc_next     = ard_pkg::DVD_W'(req.bias);
                    mcand_next   = ard_pkg::DVD_W'(req.mcand);
                    kbits_next   = ard_pkg::RATE_SCALE;
                    divisor_next = req.divisor;
                    rem_next     = '0;
                    cnt_next     = '0;
                    state_next   = D_MUL;
                end
            end
            D_MUL:
            begin
                if (kbits_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = mcand_reg << 1;
                kbits_next = kbits_reg >> 1;
                // last set bit of the scale constant
                if (kbits_reg == ard_pkg::SCALE_W'(1))
                begin
                    state_next = D_DIV;
                end
            end
            D_DIV:
            begin
                if (ge)
                begin
                    rem_next = diff[ard_pkg::LTS_W-1:0];
                end
                else
                begin
                    rem_next = partial[ard_pkg::LTS_W-1:0];
                end
                quo_next = {quo_reg[ard_pkg::DVD_W-2:0], ge};
                acc_next = acc_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ard_pkg::CNT_W'(ard_pkg::DVD_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                    if (quo_next > ard_pkg::DVD_W'(ard_pkg::ESAT))
                        result_next = ard_pkg::ESAT;
                    else
                        result_next = quo_next[ard_pkg::QUO_W-1:0];
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kbits_reg   <= kbits_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        result_reg  <= result_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = result_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held more than one cycle");

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == D_DIV)
        else $error("divider done without a divide pass");

endmodule
